// ----- src/c_subset_lexer_top_assert.svh -----
// Assertion macros used by the lexer queue module csl_queue.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// check in the same cycle
`define CSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the next cycle
`define CSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/csl_pkg.sv -----
// Shared types, constants and helper functions of the lexer.
// Used by csl_front, csl_queue, csl_back and c_subset_lexer_top.
package csl_pkg;

    localparam longint unsigned TEXT_BYTES = 64'd65536;
    localparam logic [15:0] POS_MAX = (TEXT_BYTES - 64'd1 < 64'd65535) ?
                                      16'(TEXT_BYTES - 64'd1) : 16'hFFFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] WORD_INT    [3] = '{"i", "n", "t"};
    localparam logic [7:0] WORD_RETURN [6] = '{"r", "e", "t", "u", "r", "n"};

    typedef enum logic [3:0] {
        K_INT     = 4'd0,
        K_IDENT   = 4'd1,
        K_RETURN  = 4'd2,
        K_NUMBER  = 4'd3,
        K_SEMI    = 4'd4,
        K_LBRACE  = 4'd5,
        K_RBRACE  = 4'd6,
        K_LPAREN  = 4'd7,
        K_RPAREN  = 4'd8,
        K_ASSIGN  = 4'd9,
        K_EOF     = 4'd10,
        K_UNKNOWN = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        KW_NONE   = 2'd0,
        KW_INT    = 2'd1,
        KW_RETURN = 2'd2
    } t_kw;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_entry;

    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_q_status;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < POS_MAX) ? v + 16'd1 : POS_MAX;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            ";":     k = K_SEMI;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "=":     k = K_ASSIGN;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic kw_keep(input t_kw kw, input logic [15:0] idx,
                                     input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        case (kw)
            KW_INT: begin
                if (idx < 16'd3) ok = (c == WORD_INT[idx[1:0]]);
            end
            KW_RETURN: begin
                if (idx < 16'd6) ok = (c == WORD_RETURN[idx[2:0]]);
            end
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

// ----- src/csl_front.sv -----
// Front end: accepts text bytes, tracks the pending run and forms token entries.
// Depends on csl_pkg.
module csl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output csl_pkg::t_entry   o_entry
);

    csl_pkg::t_mode  r_mode, n_mode;
    csl_pkg::t_kw    r_kw, n_kw;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_start, n_start;
    logic [15:0]     r_len, n_len;

    logic            accept;
    logic            has_run;
    logic            do_flush;
    logic            do_own;
    csl_pkg::t_kind  flush_kind;
    csl_pkg::t_token flush_tok;
    csl_pkg::t_token own_tok;

    always_comb begin
        has_run = (r_mode != csl_pkg::MODE_IDLE);
        if (r_mode == csl_pkg::MODE_NUMBER) begin
            flush_kind = csl_pkg::K_NUMBER;
        end else if (r_kw == csl_pkg::KW_INT && r_len == 16'd3) begin
            flush_kind = csl_pkg::K_INT;
        end else if (r_kw == csl_pkg::KW_RETURN && r_len == 16'd6) begin
            flush_kind = csl_pkg::K_RETURN;
        end else begin
            flush_kind = csl_pkg::K_IDENT;
        end
        flush_tok = '{kind: flush_kind, start: r_start, length: r_len};
        own_tok   = '{kind: csl_pkg::punct_kind(i_text_byte), start: r_pos, length: 16'd1};

        n_mode   = r_mode;
        n_kw     = r_kw;
        n_pos    = csl_pkg::sat_inc(r_pos);
        n_start  = r_start;
        n_len    = r_len;
        do_flush = 1'b0;
        do_own   = 1'b0;

        if (i_end_of_text) begin
            do_flush = has_run;
            do_own   = 1'b1;
            own_tok  = '{kind: csl_pkg::K_EOF, start: r_pos, length: 16'd0};
            n_mode   = csl_pkg::MODE_IDLE;
            n_kw     = csl_pkg::KW_NONE;
            n_pos    = 16'd0;
            n_start  = 16'd0;
            n_len    = 16'd0;
        end else if (csl_pkg::is_letter(i_text_byte)) begin
            if (r_mode == csl_pkg::MODE_IDENT) begin
                n_kw  = csl_pkg::kw_keep(r_kw, r_len, i_text_byte) ? r_kw : csl_pkg::KW_NONE;
                n_len = csl_pkg::sat_inc(r_len);
            end else begin
                do_flush = has_run;
                n_mode   = csl_pkg::MODE_IDENT;
                n_start  = r_pos;
                n_len    = 16'd1;
                if (i_text_byte == "i") begin
                    n_kw = csl_pkg::KW_INT;
                end else if (i_text_byte == "r") begin
                    n_kw = csl_pkg::KW_RETURN;
                end else begin
                    n_kw = csl_pkg::KW_NONE;
                end
            end
        end else if (csl_pkg::is_digit(i_text_byte)) begin
            if (has_run) begin
                n_kw  = csl_pkg::kw_keep(r_kw, r_len, i_text_byte) ? r_kw : csl_pkg::KW_NONE;
                n_len = csl_pkg::sat_inc(r_len);
            end else begin
                n_mode  = csl_pkg::MODE_NUMBER;
                n_start = r_pos;
                n_len   = 16'd1;
                n_kw    = csl_pkg::KW_NONE;
            end
        end else begin
            do_flush = has_run;
            do_own   = !csl_pkg::is_space(i_text_byte);
            n_mode   = csl_pkg::MODE_IDLE;
            n_kw     = csl_pkg::KW_NONE;
            n_len    = 16'd0;
        end
    end

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept && (do_flush || do_own);
    assign o_entry    = '{two:  do_flush && do_own,
                          tok0: do_flush ? flush_tok : own_tok,
                          tok1: own_tok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= csl_pkg::MODE_IDLE;
            r_kw    <= csl_pkg::KW_NONE;
            r_pos   <= 16'd0;
            r_start <= 16'd0;
            r_len   <= 16'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_kw    <= n_kw;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

endmodule

// ----- src/csl_queue.sv -----
// Short queue of token entries between the front and back ends.
// Depends on csl_pkg and c_subset_lexer_top_assert.svh.
`include "c_subset_lexer_top_assert.svh"

module csl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csl_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output csl_pkg::t_q_status o_status
);

    csl_pkg::t_entry              r_mem [csl_pkg::QDEPTH];
    logic [csl_pkg::QAW-1:0]      r_wr, n_wr;
    logic [csl_pkg::QAW-1:0]      r_rd, n_rd;
    logic [csl_pkg::QCW-1:0]      r_count;
    logic                         empty;

    assign empty    = (r_count == '0);
    assign o_full   = (r_count == csl_pkg::QCW'(csl_pkg::QDEPTH));
    assign o_status = '{empty: empty, head: r_mem[r_rd]};

    assign n_wr = (r_wr == csl_pkg::QAW'(csl_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == csl_pkg::QAW'(csl_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (i_pop)  r_rd <= n_rd;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CSL_ASSERT_NOW(a_no_overflow, i_push, !o_full, "push into full queue")
    `CSL_ASSERT_NOW(a_no_underflow, i_pop, !empty, "pop from empty queue")
    `CSL_ASSERT_NOW(a_count_max, 1'b1, r_count <= csl_pkg::QCW'(csl_pkg::QDEPTH), "count beyond depth")
    `CSL_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not advance")

endmodule

// ----- src/csl_back.sv -----
// Back end: drains queue entries and sends one token per transaction.
// Depends on csl_pkg.
module csl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csl_pkg::t_q_status i_status,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output csl_pkg::t_token    o_token,
    output logic               o_last
);

    logic            r_valid;
    logic            r_pend;
    csl_pkg::t_token r_pend_tok;
    csl_pkg::t_token r_tok;
    logic            r_last;
    logic            out_free;

    assign out_free    = !r_valid || !i_out_stall;
    assign o_pop       = out_free && !r_pend && !i_status.empty;
    assign o_out_valid = r_valid;
    assign o_token     = r_tok;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_status.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_status.head.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_tok  <= r_pend_tok;
                r_last <= 1'b1;
            end else begin
                r_tok      <= i_status.head.tok0;
                r_last     <= !i_status.head.two;
                r_pend_tok <= i_status.head.tok1;
            end
        end
    end

endmodule

// ----- src/c_subset_lexer_top.sv -----
// Top level of the streaming C-subset lexer.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.

// Takes one text byte per cycle unless input stall is high and emits tokens (kind, start
// offset, length, last flag), one token per cycle at the output unless output stall is high.
// A byte that closes a pending run and yields its own token too gives two tokens, so the
// output port at one token per cycle sets the sustained rate. A four-entry queue between
// the classifying front end and the output stage absorbs such bursts; input stall rises
// only when it is full. A token is written into the queue and then registered in the
// output stage. No clearing pass follows reset.
module c_subset_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic               q_full;
    logic               push;
    logic               pop;
    csl_pkg::t_entry    entry;
    csl_pkg::t_q_status status;
    csl_pkg::t_token    token;

    csl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_entry       (entry)
    );

    csl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_status (status)
    );

    csl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (status),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_token     (token),
        .o_last      (o_last_of_run)
    );

    assign o_token_kind   = token.kind;
    assign o_token_start  = token.start;
    assign o_token_length = token.length;

endmodule
